### hdl/sbq_pkg.sv
// Shared constants and fixed-point helpers for the stereo biquad equalizer.
package sbq_pkg;

    localparam int BANDS      = 4;
    localparam int NCB        = 2 * BANDS;
    localparam int COEFS      = 5;
    localparam int HTAPS      = 4;
    localparam int COEF_DEPTH = NCB * COEFS;
    localparam int HIST_DEPTH = NCB * HTAPS;
    localparam int CB_W       = $clog2(NCB);
    localparam int COEF_AW    = $clog2(COEF_DEPTH);
    localparam int HIST_AW    = $clog2(HIST_DEPTH);

    localparam logic [31:0] COEF_ONE = 32'h1000_0000;
    localparam logic [15:0] W_OLD    = 16'd64881;
    localparam logic [15:0] W_NEW    = 16'd655;

    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_COEF   = 2'd1;
    localparam logic [1:0] CMD_ENERGY = 2'd2;

    localparam logic [1:0] REG_IN_GAIN  = 2'd0;
    localparam logic [1:0] REG_OUT_TRIM = 2'd1;
    localparam logic [1:0] REG_MID_SIDE = 2'd2;
    localparam logic [1:0] REG_BAND_EN  = 2'd3;

    function automatic logic signed [23:0] sat24(input logic signed [59:0] v);
        logic signed [23:0] r;
        if (v > 60'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (v < -60'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

    // Round half up by 2^12, then clamp.
    function automatic logic signed [23:0] rnd_sat12(input logic signed [58:0] p);
        logic signed [59:0] t;
        t = (60'(p) + 60'sd2048) >>> 12;
        return sat24(t);
    endfunction

    // Round half up by 2^28, then clamp.
    function automatic logic signed [23:0] rnd_sat28(input logic signed [59:0] a);
        logic signed [59:0] t;
        t = (a + 60'sd134217728) >>> 28;
        return sat24(t);
    endfunction

endpackage

### hdl/sbq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module sbq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### hdl/stereo_biquad_cascade_eq.sv
// Stereo biquad cascade equalizer with mid/side option and band energy envelopes.
// Sample transfer: input gain, then the band cascade of each channel in turn, then output trim;
// every band of each channel runs on the one shared 33x26 multiplier.
// A coefficient write or unused command goes straight to the output; an energy read
// first reads the energy memory. One item is in work at a time; the output register
// lets the next transfer in the cycle after the result is registered.
// Synchronous active-low reset sets control registers and marks all memory entries unwritten.
module stereo_biquad_cascade_eq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_cmd,
    input  logic signed [23:0] i_left_in,
    input  logic signed [23:0] i_right_in,
    input  logic               i_channel_sel,
    input  logic [2:0]         i_band_sel,
    input  logic [2:0]         i_coef_slot,
    input  logic signed [31:0] i_coef_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [23:0] o_left_out,
    output logic signed [23:0] o_right_out,
    output logic [23:0]        o_energy_out
);
    import sbq_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GAIN = 3'd1;
    localparam logic [2:0] S_BAND = 3'd2;
    localparam logic [2:0] S_TRIM = 3'd3;
    localparam logic [2:0] S_ERD  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    localparam logic [3:0] ST_LAST = 4'd10;

    // control state
    logic [2:0]            r_state;
    logic [3:0]            r_step;
    logic [CB_W-1:0]       r_cb;
    logic [15:0]           r_in_gain;
    logic [15:0]           r_out_trim;
    logic                  r_mid_side;
    logic [15:0]           r_band_en;
    logic [COEF_DEPTH-1:0] r_coef_vld;
    logic [HIST_DEPTH-1:0] r_hist_vld;
    logic [NCB-1:0]        r_en_vld;

    // payload
    logic signed [23:0] r_lin, r_rin;
    logic               r_eok;
    logic signed [23:0] r_gl;
    logic signed [23:0] r_x, r_xin1, r_y, r_y0;
    logic signed [23:0] r_h0, r_h2;
    logic [23:0]        r_e, r_d;
    logic signed [58:0] r_prod;
    logic signed [59:0] r_acc;
    logic [41:0]        r_eacc;
    logic signed [23:0] r_res_l, r_res_r;
    logic [23:0]        r_res_e;
    logic               r_cvld_q, r_cone_q, r_hvld_q, r_evld_q;

    logic accept;
    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // Address of the channel and band named by a command.
    logic [4:0]      sel_cbw;
    logic [CB_W-1:0] sel_cb;
    logic            band_ok;
    assign sel_cbw = 5'(i_band_sel) + (i_channel_sel ? 5'(BANDS) : 5'd0);
    assign sel_cb  = sel_cbw[CB_W-1:0];
    assign band_ok = (4'(i_band_sel) < 4'(BANDS));

    // Current channel and band of the cascade walk.
    logic            cur_ch;
    logic [CB_W-1:0] cur_band;
    logic            band_on;
    assign cur_ch   = (r_cb >= CB_W'(BANDS));
    assign cur_band = cur_ch ? r_cb - CB_W'(BANDS) : r_cb;
    assign band_on  = r_band_en[{cur_ch, 3'(cur_band)}];

    // Coefficient memory: written by command, read one slot per cycle.
    logic               coef_we;
    logic [COEF_AW-1:0] coef_waddr, coef_raddr;
    logic [2:0]         coef_rslot;
    logic [31:0]        coef_rd;
    logic signed [31:0] coef_eff;
    assign coef_we    = accept && (i_cmd == CMD_COEF) && band_ok && (i_coef_slot < 3'(COEFS));
    assign coef_waddr = COEF_AW'(8'(sel_cbw) * 8'(COEFS) + 8'(i_coef_slot));
    assign coef_rslot = (r_step < 4'(COEFS)) ? r_step[2:0] : 3'd0;
    assign coef_raddr = COEF_AW'(8'(r_cb) * 8'(COEFS) + 8'(coef_rslot));
    assign coef_eff   = r_cvld_q ? coef_rd : (r_cone_q ? COEF_ONE : 32'd0);

    sbq_ram #(.WIDTH(32), .DEPTH(COEF_DEPTH)) u_coef_ram (
        .i_clk  (i_clk),
        .i_we   (coef_we),
        .i_waddr(coef_waddr),
        .i_wdata(i_coef_word),
        .i_raddr(coef_raddr),
        .o_rdata(coef_rd)
    );

    // History memory: taps x1, x2, y1, y2 per band; read steps 1..4, written steps 7..10.
    logic               hist_we;
    logic [HIST_AW-1:0] hist_waddr, hist_raddr;
    logic [23:0]        hist_wdata, hist_rd;
    logic signed [23:0] hist_eff;
    logic [1:0]         tap_r, tap_w;
    assign tap_r      = 2'(r_step - 4'd1);
    assign tap_w      = 2'(r_step - 4'd7);
    assign hist_raddr = HIST_AW'(8'(r_cb) * 8'(HTAPS) + 8'(tap_r));
    assign hist_waddr = HIST_AW'(8'(r_cb) * 8'(HTAPS) + 8'(tap_w));
    assign hist_we    = (r_state == S_BAND) && (r_step >= 4'd7) && band_on;
    assign hist_eff   = r_hvld_q ? hist_rd : 24'd0;

    always_comb begin
        unique case (tap_w)
            2'd0:    hist_wdata = r_x;
            2'd1:    hist_wdata = r_h0;
            2'd2:    hist_wdata = r_y;
            default: hist_wdata = r_h2;
        endcase
    end

    sbq_ram #(.WIDTH(24), .DEPTH(HIST_DEPTH)) u_hist_ram (
        .i_clk  (i_clk),
        .i_we   (hist_we),
        .i_waddr(hist_waddr),
        .i_wdata(hist_wdata),
        .i_raddr(hist_raddr),
        .o_rdata(hist_rd)
    );

    // Energy memory: one envelope per band and channel.
    logic            en_we;
    logic [CB_W-1:0] en_raddr;
    logic [23:0]     en_rd, en_new;
    logic [41:0]     en_sum;
    assign en_we    = (r_state == S_BAND) && (r_step == ST_LAST);
    assign en_raddr = (r_state == S_IDLE) ? sel_cb : r_cb;
    assign en_sum   = r_eacc + r_prod[41:0] + 42'd32768;
    assign en_new   = en_sum[39:16];

    sbq_ram #(.WIDTH(24), .DEPTH(NCB)) u_energy_ram (
        .i_clk  (i_clk),
        .i_we   (en_we),
        .i_waddr(r_cb),
        .i_wdata(en_new),
        .i_raddr(en_raddr),
        .o_rdata(en_rd)
    );

    // Gain, mid/side encode and decode.
    logic signed [23:0] g_r, enc_a, enc_b;
    logic signed [24:0] sum_lr, dif_lr, dec_l, dec_r;
    assign g_r    = rnd_sat12(r_prod);
    assign sum_lr = 25'(r_gl) + 25'(g_r);
    assign dif_lr = 25'(r_gl) - 25'(g_r);
    assign enc_a  = sum_lr[24:1];
    assign enc_b  = dif_lr[24:1];
    assign dec_l  = r_mid_side ? 25'(r_y0) + 25'(r_y) : 25'(r_y0);
    assign dec_r  = r_mid_side ? 25'(r_y0) - 25'(r_y) : 25'(r_y);

    // Band output and change magnitude.
    logic signed [23:0] band_y;
    logic signed [24:0] band_dif;
    logic [24:0]        band_abs;
    assign band_y   = band_on ? rnd_sat28(r_acc) : r_x;
    assign band_dif = 25'(band_y) - 25'(r_x);
    assign band_abs = band_dif[24] ? 25'(-band_dif) : 25'(band_dif);

    // Shared multiplier operands.
    logic signed [32:0] mul_a;
    logic signed [25:0] mul_b;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_GAIN: begin
                mul_a = 33'(r_in_gain);
                mul_b = (r_step == 4'd0) ? 26'(r_lin) : 26'(r_rin);
            end
            S_BAND: begin
                if (r_step == 4'd8) begin
                    mul_a = 33'(W_OLD);
                    mul_b = 26'(r_e);
                end else if (r_step == 4'd9) begin
                    mul_a = 33'(W_NEW);
                    mul_b = 26'(r_d);
                end else begin
                    mul_a = 33'(coef_eff);
                    mul_b = (r_step == 4'd1) ? 26'(r_x) : 26'(hist_eff);
                end
            end
            S_TRIM: begin
                mul_a = 33'(r_out_trim);
                mul_b = (r_step == 4'd0) ? 26'(dec_l) : 26'(dec_r);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Control: state walk, configuration, memory valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_cb        <= '0;
            r_in_gain   <= 16'd4096;
            r_out_trim  <= 16'd4096;
            r_mid_side  <= 1'b0;
            r_band_en   <= '0;
            r_coef_vld  <= '0;
            r_hist_vld  <= '0;
            r_en_vld    <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_IN_GAIN:  r_in_gain  <= i_cfg_data;
                    REG_OUT_TRIM: r_out_trim <= i_cfg_data;
                    REG_MID_SIDE: r_mid_side <= i_cfg_data[0];
                    REG_BAND_EN:  r_band_en  <= i_cfg_data;
                    default:      r_band_en  <= r_band_en;
                endcase
            end
            if (coef_we) begin
                r_coef_vld[coef_waddr] <= 1'b1;
            end
            if (hist_we) begin
                r_hist_vld[hist_waddr] <= 1'b1;
            end
            if (en_we) begin
                r_en_vld[r_cb] <= 1'b1;
            end
            // Drop valid after the transfer unless a new result replaces it.
            if (o_out_valid && i_out_ready && (r_state != S_OUT)) begin
                o_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    r_step <= '0;
                    r_cb   <= '0;
                    if (accept) begin
                        priority if (i_cmd == CMD_SAMPLE) begin
                            r_state <= S_GAIN;
                        end else if (i_cmd == CMD_ENERGY) begin
                            r_state <= S_ERD;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_GAIN, S_TRIM: begin
                    if (r_step == 4'd2) begin
                        r_step  <= '0;
                        r_state <= (r_state == S_GAIN) ? S_BAND : S_OUT;
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                S_BAND: begin
                    if (r_step == ST_LAST) begin
                        r_step <= '0;
                        if (r_cb == CB_W'(NCB - 1)) begin
                            r_state <= S_TRIM;
                        end else begin
                            r_cb <= r_cb + 1'b1;
                        end
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                S_ERD: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // Hold the result until the output register is free.
                    if (!o_out_valid || i_out_ready) begin
                        o_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_prod   <= mul_a * mul_b;
        r_cvld_q <= r_coef_vld[coef_raddr];
        r_cone_q <= (coef_rslot == 3'd0);
        r_hvld_q <= r_hist_vld[hist_raddr];
        r_evld_q <= r_en_vld[en_raddr];

        if (accept) begin
            r_lin   <= i_left_in;
            r_rin   <= i_right_in;
            r_eok   <= band_ok;
            r_res_l <= '0;
            r_res_r <= '0;
            r_res_e <= '0;
        end

        unique case (r_state)
            S_GAIN: begin
                if (r_step == 4'd1) begin
                    r_gl <= rnd_sat12(r_prod);
                end
                if (r_step == 4'd2) begin
                    r_x    <= r_mid_side ? enc_a : r_gl;
                    r_xin1 <= r_mid_side ? enc_b : g_r;
                end
            end
            S_BAND: begin
                unique case (r_step)
                    4'd1: r_e <= r_evld_q ? en_rd : 24'd0;
                    4'd2: begin
                        r_acc <= 60'(r_prod);
                        r_h0  <= hist_eff;
                    end
                    4'd3: r_acc <= r_acc + 60'(r_prod);
                    4'd4: begin
                        r_acc <= r_acc + 60'(r_prod);
                        r_h2  <= hist_eff;
                    end
                    4'd5, 4'd6: r_acc <= r_acc - 60'(r_prod);
                    4'd7: begin
                        r_y <= band_y;
                        r_d <= band_abs[23:0];
                    end
                    4'd9: r_eacc <= r_prod[41:0];
                    ST_LAST: begin
                        // Advance to the next band; switch channel after the last one.
                        if (r_cb == CB_W'(BANDS - 1)) begin
                            r_y0 <= r_y;
                            r_x  <= r_xin1;
                        end else begin
                            r_x <= r_y;
                        end
                    end
                    default: r_acc <= r_acc;
                endcase
            end
            S_TRIM: begin
                if (r_step == 4'd1) begin
                    r_res_l <= rnd_sat12(r_prod);
                end
                if (r_step == 4'd2) begin
                    r_res_r <= rnd_sat12(r_prod);
                end
            end
            S_ERD: begin
                r_res_e <= (r_eok && r_evld_q) ? en_rd : 24'd0;
            end
            S_OUT: begin
                if (!o_out_valid || i_out_ready) begin
                    o_left_out   <= r_res_l;
                    o_right_out  <= r_res_r;
                    o_energy_out <= r_res_e;
                end
            end
            default: r_acc <= r_acc;
        endcase
    end

    // A sample transfer starts the cascade and closes the input.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd == CMD_SAMPLE) |=> (r_state == S_GAIN && !o_in_ready))
        else $error("sample transfer did not start the cascade");

    // No coefficient write lands while the cascade reads coefficients.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BAND) |-> !coef_we)
        else $error("coefficient write during band processing");

    // The band walk stays inside the memories.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BAND) |-> (r_cb <= CB_W'(NCB - 1) && r_step <= ST_LAST))
        else $error("band walk out of range");

    // History is written only for an enabled band.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hist_we |-> (band_on && r_step >= 4'd7))
        else $error("history write for a bypassed band");

endmodule
